>>> hdl/i2c_eba_pkg.sv
// shared types and constants for the i2c eeprom byte access block
// no dependencies
`timescale 1ns / 1ps

package i2c_eba_pkg;

    // raw command codes on the input channel
    localparam logic [1:0] RAW_CMD_WRITE = 2'd1;
    localparam logic [1:0] RAW_CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_DEVICE_SELECT = 1'b0;
    localparam logic CFG_ACK_TIMEOUT   = 1'b1;

    localparam int CFG_DATA_W = 10;

    localparam logic [6:0] DEVICE_SELECT_RESET = 7'd80;
    localparam logic [9:0] ACK_TIMEOUT_RESET   = 10'd200;
    localparam logic [3:0] BITS_PER_BYTE       = 4'd8;

    // classified request
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // one queued tick
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] word_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_tick;

    // queue head as seen by the sequencer
    typedef struct packed {
        logic  valid;
        t_tick tick;
    } t_queue_head;

    // one result tick
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } t_result;

endpackage

>>> hdl/i2c_eba_if.sv
// valid/ready channel interfaces for ticks in and results out
// depends on i2c_eba_pkg
`timescale 1ns / 1ps

interface i2c_eba_in_if import i2c_eba_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, command, word_address, write_data, sda_in, input ready);
    modport sink   (input valid, command, word_address, write_data, sda_in, output ready);
endinterface

interface i2c_eba_out_if import i2c_eba_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;

    modport source (output valid, scl, sda_out, busy_res, done_res, read_data, ack_error,
                    input ready);
    modport sink   (input valid, scl, sda_out, busy_res, done_res, read_data, ack_error,
                    output ready);
endinterface

>>> hdl/i2c_eeprom_byte_access.sv
// top level of the i2c eeprom byte access block: front queue plus bus sequencer
// depends on i2c_eba_pkg, i2c_eba_if, i2c_eba_front and i2c_eba_back
//
// every transaction on i_tick is one quarter period tick of the i2c bus and yields exactly
// one transaction on o_result carrying the scl and sda drive after that tick, busy, done,
// the last read byte and the ack error flag. a request (byte write or random byte read) is
// taken only while the sequencer is idle; requests seen while busy are dropped. one tick
// is taken every clock cycle in steady state while o_result is not stalled; the result of
// a tick is presented on o_result once the accepting edge has written it into the two-entry
// queue and the sequencer has then taken it and loaded the result register. the throughput
// is set by the single-step phase sequencer, which advances at most one bus phase per tick.
// a result held by a stalled receiver holds the sequencer; the queue then fills and
// i_tick.ready drops once it holds two ticks. configuration writes (index 0 device select,
// index 1 ack timeout) take effect on the next clock edge and are meant for idle periods.
`timescale 1ns / 1ps

module i2c_eeprom_byte_access import i2c_eba_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    i2c_eba_in_if.sink            i_tick,
    i2c_eba_out_if.source         o_result
);

    t_queue_head w_head;
    logic        w_pop;
    t_result     w_result;

    // front: command decode and tick queue
    i2c_eba_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_tick.valid),
        .o_ready        (i_tick.ready),
        .i_command      (i_tick.command),
        .i_word_address (i_tick.word_address),
        .i_write_data   (i_tick.write_data),
        .i_sda_in       (i_tick.sda_in),
        .o_head         (w_head),
        .i_pop          (w_pop)
    );

    // back: phase sequencer with its result register
    i2c_eba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_result.valid),
        .i_ready     (o_result.ready),
        .o_result    (w_result)
    );

    assign o_result.scl       = w_result.scl;
    assign o_result.sda_out   = w_result.sda_out;
    assign o_result.busy_res  = w_result.busy_res;
    assign o_result.done_res  = w_result.done_res;
    assign o_result.read_data = w_result.read_data;
    assign o_result.ack_error = w_result.ack_error;

endmodule

>>> hdl/i2c_eba_front.sv
// front end: classifies incoming ticks and holds them in a two-entry queue
// depends on i2c_eba_pkg
`timescale 1ns / 1ps

module i2c_eba_front import i2c_eba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_word_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_sda_in,
    output t_queue_head o_head,
    input  logic        i_pop
);

    t_tick      r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_tick      w_tick;
    logic       w_push;

    always_comb begin
        unique case (i_command)
            RAW_CMD_WRITE: w_tick.cmd = CMD_WRITE;
            RAW_CMD_READ:  w_tick.cmd = CMD_READ;
            default:       w_tick.cmd = CMD_NONE;
        endcase
        w_tick.word_address = i_word_address;
        w_tick.write_data   = i_write_data;
        w_tick.sda_in       = i_sda_in;
    end

    assign o_ready = (r_count != 2'd2);
    assign w_push  = i_valid && o_ready;

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.tick  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/i2c_eba_back.sv
// back end: bus phase sequencer, configuration registers and result register
// depends on i2c_eba_pkg
`timescale 1ns / 1ps

module i2c_eba_back import i2c_eba_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_queue_head           i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_result
);

    typedef enum logic [18:0] {
        ST_IDLE    = 19'h00001,
        ST_S_SCLHI = 19'h00002,
        ST_S_SDALO = 19'h00004,
        ST_S_SCLLO = 19'h00008,
        ST_S_SDAHI = 19'h00010,
        ST_TX_SET  = 19'h00020,
        ST_TX_RISE = 19'h00040,
        ST_TX_FALL = 19'h00080,
        ST_AK_REL  = 19'h00100,
        ST_AK_RISE = 19'h00200,
        ST_AK_WAIT = 19'h00400,
        ST_RX_RISE = 19'h00800,
        ST_RX_FALL = 19'h01000,
        ST_NK_REL  = 19'h02000,
        ST_NK_RISE = 19'h04000,
        ST_NK_FALL = 19'h08000,
        ST_P_SDALO = 19'h10000,
        ST_P_SCLHI = 19'h20000,
        ST_P_SDAHI = 19'h40000
    } t_step;

    logic [6:0] r_dev_sel;
    logic [9:0] r_ack_timeout;

    t_step      r_step,     n_step;
    logic [3:0] r_bit_cnt,  n_bit_cnt;
    logic [1:0] r_byte_cnt, n_byte_cnt;
    logic [7:0] r_shift,    n_shift;
    logic [9:0] r_ack_cnt,  n_ack_cnt;
    logic       r_op_read,  n_op_read;
    logic [7:0] r_addr,     n_addr;
    logic [7:0] r_data,     n_data;
    logic [7:0] r_rx,       n_rx;
    logic       r_err,      n_err;
    logic       r_scl,      n_scl;
    logic       r_sda,      n_sda;
    logic       n_done;
    logic       w_finish;
    t_tick      w_tick;

    assign w_tick = i_head.tick;
    assign o_pop  = i_head.valid && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_sel     <= DEVICE_SELECT_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEVICE_SELECT: r_dev_sel     <= i_cfg_data[6:0];
                CFG_ACK_TIMEOUT:   r_ack_timeout <= i_cfg_data;
                default:           r_dev_sel     <= r_dev_sel;
            endcase
        end
    end

    always_comb begin
        n_step     = r_step;
        n_bit_cnt  = r_bit_cnt;
        n_byte_cnt = r_byte_cnt;
        n_shift    = r_shift;
        n_ack_cnt  = r_ack_cnt;
        n_op_read  = r_op_read;
        n_addr     = r_addr;
        n_data     = r_data;
        n_rx       = r_rx;
        n_err      = r_err;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_done     = 1'b0;
        w_finish   = 1'b0;

        unique case (r_step)
            ST_IDLE: begin
                if (w_tick.cmd == CMD_WRITE || w_tick.cmd == CMD_READ) begin
                    n_op_read  = (w_tick.cmd == CMD_READ);
                    n_addr     = w_tick.word_address;
                    n_data     = w_tick.write_data;
                    n_err      = 1'b0;
                    n_byte_cnt = 2'd0;
                    n_bit_cnt  = 4'd0;
                    n_ack_cnt  = 10'd0;
                    n_sda      = 1'b1;
                    n_step     = ST_S_SCLHI;
                end
            end
            ST_S_SDAHI: begin
                n_sda  = 1'b1;
                n_step = ST_S_SCLHI;
            end
            ST_S_SCLHI: begin
                n_scl  = 1'b1;
                n_step = ST_S_SDALO;
            end
            ST_S_SDALO: begin
                n_sda  = 1'b0;
                n_step = ST_S_SCLLO;
            end
            ST_S_SCLLO: begin
                n_scl     = 1'b0;
                n_shift   = {r_dev_sel, (r_byte_cnt != 2'd0)};
                n_bit_cnt = 4'd0;
                n_step    = ST_TX_SET;
            end
            ST_TX_SET: begin
                n_sda   = r_shift[7];
                n_shift = {r_shift[6:0], 1'b0};
                n_step  = ST_TX_RISE;
            end
            ST_TX_RISE: begin
                n_scl  = 1'b1;
                n_step = ST_TX_FALL;
            end
            ST_TX_FALL: begin
                n_scl     = 1'b0;
                n_bit_cnt = r_bit_cnt + 4'd1;
                n_step    = (n_bit_cnt >= BITS_PER_BYTE) ? ST_AK_REL : ST_TX_SET;
            end
            ST_AK_REL: begin
                n_sda  = 1'b1;
                n_step = ST_AK_RISE;
            end
            ST_AK_RISE: begin
                n_scl     = 1'b1;
                n_ack_cnt = 10'd0;
                n_step    = ST_AK_WAIT;
            end
            ST_AK_WAIT: begin
                if (!w_tick.sda_in) begin
                    w_finish = 1'b1;
                end else if (r_ack_cnt >= r_ack_timeout) begin
                    n_err    = 1'b1;
                    w_finish = 1'b1;
                end else begin
                    n_ack_cnt = r_ack_cnt + 10'd1;
                end
                if (w_finish) begin
                    n_scl     = 1'b0;
                    n_ack_cnt = 10'd0;
                    if (r_byte_cnt == 2'd0) begin
                        // device select sent, word address next
                        n_byte_cnt = 2'd1;
                        n_shift    = r_addr;
                        n_bit_cnt  = 4'd0;
                        n_step     = ST_TX_SET;
                    end else if (r_byte_cnt == 2'd1) begin
                        n_byte_cnt = 2'd2;
                        if (!r_op_read) begin
                            n_shift   = r_data;
                            n_bit_cnt = 4'd0;
                            n_step    = ST_TX_SET;
                        end else begin
                            // repeated start for the read phase
                            n_step = ST_S_SDAHI;
                        end
                    end else if (!r_op_read) begin
                        n_step = ST_P_SDALO;
                    end else begin
                        n_bit_cnt = 4'd0;
                        n_shift   = 8'd0;
                        n_step    = ST_RX_RISE;
                    end
                end
            end
            ST_RX_RISE: begin
                n_scl  = 1'b1;
                n_step = ST_RX_FALL;
            end
            ST_RX_FALL: begin
                n_shift   = {r_shift[6:0], w_tick.sda_in};
                n_scl     = 1'b0;
                n_bit_cnt = r_bit_cnt + 4'd1;
                if (n_bit_cnt >= BITS_PER_BYTE) begin
                    n_rx   = n_shift;
                    n_step = ST_NK_REL;
                end else begin
                    n_step = ST_RX_RISE;
                end
            end
            ST_NK_REL: begin
                n_sda  = 1'b1;
                n_step = ST_NK_RISE;
            end
            ST_NK_RISE: begin
                n_scl  = 1'b1;
                n_step = ST_NK_FALL;
            end
            ST_NK_FALL: begin
                n_scl  = 1'b0;
                n_step = ST_P_SDALO;
            end
            ST_P_SDALO: begin
                n_sda  = 1'b0;
                n_step = ST_P_SCLHI;
            end
            ST_P_SCLHI: begin
                n_scl  = 1'b1;
                n_step = ST_P_SDAHI;
            end
            ST_P_SDAHI: begin
                n_sda  = 1'b1;
                n_done = 1'b1;
                n_step = ST_IDLE;
            end
            default: begin
                n_scl  = 1'b1;
                n_sda  = 1'b1;
                n_step = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ST_IDLE;
            r_bit_cnt  <= 4'd0;
            r_byte_cnt <= 2'd0;
            r_shift    <= 8'd0;
            r_ack_cnt  <= 10'd0;
            r_op_read  <= 1'b0;
            r_addr     <= 8'd0;
            r_data     <= 8'd0;
            r_rx       <= 8'd0;
            r_err      <= 1'b0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
        end else if (o_pop) begin
            r_step     <= n_step;
            r_bit_cnt  <= n_bit_cnt;
            r_byte_cnt <= n_byte_cnt;
            r_shift    <= n_shift;
            r_ack_cnt  <= n_ack_cnt;
            r_op_read  <= n_op_read;
            r_addr     <= n_addr;
            r_data     <= n_data;
            r_rx       <= n_rx;
            r_err      <= n_err;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (o_pop) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_result.scl       <= n_scl;
            o_result.sda_out   <= n_sda;
            o_result.busy_res  <= (n_step != ST_IDLE);
            o_result.done_res  <= n_done;
            o_result.read_data <= n_rx;
            o_result.ack_error <= n_err;
        end
    end

endmodule
